[hdl/dss_pkg.sv]
// dss_pkg: shared types and constants of the disk seek scheduler
// no dependencies; used by every module under hdl
package dss_pkg;

	localparam int POS_W     = 16;
	localparam int TRAVEL_W  = 22;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_POSITION = 1'd1;

	localparam logic POLICY_FCFS = 1'b0;
	localparam logic POLICY_SCAN = 1'b1;

	localparam logic PHASE_UP   = 1'b0;
	localparam logic PHASE_DOWN = 1'b1;

	typedef struct packed {
		logic [POS_W-1:0] request_position;
		logic             last_request;
	} request_t;

	typedef struct packed {
		logic [POS_W-1:0]    from_position;
		logic [POS_W-1:0]    to_position;
		logic [TRAVEL_W-1:0] total_travel;
		logic                last_move;
	} result_t;

	typedef struct packed {
		logic             init;
		logic [POS_W-1:0] start_pos;
		logic             emit;
		logic [POS_W-1:0] target;
		logic             last;
	} move_cmd_t;

endpackage

[hdl/dss_req_mem.sv]
// dss_req_mem: request store, one write port and one registered read port
// depends on dss_pkg
module dss_req_mem
	import dss_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [POS_W-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [POS_W-1:0] rdata
);

	logic [POS_W-1:0] mem_q [DEPTH];
	logic [POS_W-1:0] rdata_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_s1 <= mem_q[raddr];
	end

	assign rdata = rdata_s1;

endmodule

[hdl/dss_move_unit.sv]
// dss_move_unit: head position, travel total and the registered result
// depends on dss_pkg
module dss_move_unit
	import dss_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  move_cmd_t cmd,
	output result_t   result,
	output logic      result_valid
);

	logic [POS_W-1:0]    head_q;
	logic [TRAVEL_W-1:0] travel_q;
	logic [POS_W-1:0]    seek_len;
	logic [TRAVEL_W-1:0] travel_n;
	result_t             result_q;
	logic                valid_q;

	always_comb begin
		seek_len = (cmd.target >= head_q) ? (cmd.target - head_q) : (head_q - cmd.target);
		travel_n = travel_q + TRAVEL_W'(seek_len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			travel_q <= '0;
			valid_q  <= 1'b0;
		end else begin
			valid_q <= cmd.emit;
			if (cmd.init) begin
				head_q   <= cmd.start_pos;
				travel_q <= '0;
			end else if (cmd.emit) begin
				head_q   <= cmd.target;
				travel_q <= travel_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.from_position <= head_q;
			result_q.to_position   <= cmd.target;
			result_q.total_travel  <= travel_n;
			result_q.last_move     <= cmd.last;
		end
	end

	assign result       = result_q;
	assign result_valid = valid_q;

endmodule

[hdl/disk_seek_scheduler_top.sv]
// Loading: a batch is taken one request a cycle; the last one (or the MAX_BATCH-th) starts service.
// Arrival order: each move is a memory read state followed by an emit state.
// Sweep order: each move takes one full pass over the request memory, a drain state and a
// decide state to pick the next cylinder, plus one more pass when the upward sweep runs out.
// A result is registered and shows in the cycle after its move is chosen; the receiver cannot stall.
// Reset clears control, head and travel; the request memory is not cleared.
module disk_seek_scheduler_top
	import dss_pkg::*;
#(
	parameter int MAX_BATCH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  request_t             request,
	output logic                 busy,
	output result_t              result,
	output logic                 result_valid,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int AW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
	localparam int CW = $clog2(MAX_BATCH + 1);
	localparam int KW = POS_W + AW;

	localparam logic [2:0] ST_LOAD   = 3'd0;
	localparam logic [2:0] ST_FREAD  = 3'd1;
	localparam logic [2:0] ST_FEMIT  = 3'd2;
	localparam logic [2:0] ST_PASS   = 3'd3;
	localparam logic [2:0] ST_DRAIN  = 3'd4;
	localparam logic [2:0] ST_DECIDE = 3'd5;

	logic [2:0]       state_q;
	logic             policy_q;
	logic [POS_W-1:0] start_pos_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    n_q;
	logic [CW-1:0]    emitted_q;
	logic             mode_q;
	logic [POS_W-1:0] start_q;
	logic             phase_q;
	logic             have_bound_q;
	logic [KW-1:0]    bound_q;
	logic             found_q;
	logic [KW-1:0]    cand_q;
	logic [AW-1:0]    idx_q;
	logic             rvalid_s1;
	logic [AW-1:0]    ridx_s1;

	logic             accept;
	logic [CW-1:0]    count_n;
	logic             batch_end;
	logic             move_last;
	logic [AW-1:0]    raddr;
	logic [POS_W-1:0] rdata;
	logic [KW-1:0]    key;
	logic             qualify;
	move_cmd_t        cmd;

	assign busy      = (state_q != ST_LOAD);
	assign accept    = start && !busy;
	assign count_n   = count_q + 1'b1;
	assign batch_end = request.last_request || (count_n == CW'(MAX_BATCH));
	assign move_last = ((emitted_q + 1'b1) == n_q);
	assign raddr     = (state_q == ST_FREAD) ? emitted_q[AW-1:0] : idx_q;
	assign key       = {rdata, ridx_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q    <= POLICY_FCFS;
			start_pos_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POLICY_MODE:    policy_q <= cfg_data[0];
				REG_START_POSITION: start_pos_q <= cfg_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	dss_req_mem #(
		.DEPTH(MAX_BATCH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (accept),
		.waddr(count_q[AW-1:0]),
		.wdata(request.request_position),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		if (phase_q == PHASE_UP) begin
			qualify = (rdata >= start_q) && (!have_bound_q || key > bound_q)
				&& (!found_q || key < cand_q);
		end else begin
			qualify = (rdata < start_q) && (!have_bound_q || key < bound_q)
				&& (!found_q || key > cand_q);
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.start_pos = start_pos_q;
		cmd.init      = accept && batch_end;
		cmd.last      = move_last;
		if (state_q == ST_FEMIT) begin
			cmd.emit   = 1'b1;
			cmd.target = rdata;
		end else if (state_q == ST_DECIDE && found_q) begin
			cmd.emit   = 1'b1;
			cmd.target = cand_q[KW-1 -: POS_W];
		end
	end

	dss_move_unit u_move (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.result      (result),
		.result_valid(result_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			count_q      <= '0;
			n_q          <= '0;
			emitted_q    <= '0;
			mode_q       <= POLICY_FCFS;
			start_q      <= '0;
			phase_q      <= PHASE_UP;
			have_bound_q <= 1'b0;
			bound_q      <= '0;
			found_q      <= 1'b0;
			cand_q       <= '0;
			idx_q        <= '0;
			rvalid_s1    <= 1'b0;
			ridx_s1      <= '0;
		end else begin
			rvalid_s1 <= (state_q == ST_PASS);
			ridx_s1   <= idx_q;
			if (rvalid_s1 && qualify) begin
				cand_q  <= key;
				found_q <= 1'b1;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (batch_end) begin
							count_q      <= '0;
							n_q          <= count_n;
							emitted_q    <= '0;
							mode_q       <= policy_q;
							start_q      <= start_pos_q;
							phase_q      <= PHASE_UP;
							have_bound_q <= 1'b0;
							found_q      <= 1'b0;
							idx_q        <= '0;
							state_q      <= (policy_q == POLICY_SCAN) ? ST_PASS : ST_FREAD;
						end else begin
							count_q <= count_n;
						end
					end
				end
				ST_FREAD: begin
					state_q <= ST_FEMIT;
				end
				ST_FEMIT: begin
					emitted_q <= emitted_q + 1'b1;
					state_q   <= move_last ? ST_LOAD : ST_FREAD;
				end
				ST_PASS: begin
					if ((CW'(idx_q) + 1'b1) == n_q) begin
						idx_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					found_q <= 1'b0;
					if (found_q) begin
						bound_q      <= cand_q;
						have_bound_q <= 1'b1;
						emitted_q    <= emitted_q + 1'b1;
						state_q      <= move_last ? ST_LOAD : ST_PASS;
					end else begin
						phase_q      <= PHASE_DOWN;
						have_bound_q <= 1'b0;
						state_q      <= ST_PASS;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_result_from_service: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without a batch in service");

	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (count_q == '0))
		else $error("load count not cleared during service");

	a_emitted_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (emitted_q < n_q))
		else $error("more moves than requests in the batch");

	a_last_move_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last_move) |-> !busy)
		else $error("service still running after the final move");

	a_mode_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && $past(busy)) |-> $stable(mode_q) && $stable(n_q))
		else $error("batch setup changed during service");
`endif

endmodule
